FILE: rtl/b62d_pkg.sv
// Shared types, constants and character decode for the base62 sextet decoder.
package b62d_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned CapW      = 16;
  localparam int unsigned CmpW      = ((CountBits > CapW) ? CountBits : CapW) + 1;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam logic [CapW-1:0] CapReset = CapW'(4096);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChEscape = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpC    = 8'h43;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7A;
  localparam logic [7:0] ChDig0   = 8'h30;
  localparam logic [7:0] ChDig8   = 8'h38;
  localparam logic [5:0] SxEscBase = 6'd61;

  typedef enum logic [0:0] {
    RegOutCapacity = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadChar  = 3'd1,
    StBadEsc   = 3'd2,
    StEscEnd   = 3'd3,
    StOverflow = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } out_t;

  typedef struct packed {
    out_t [MaxRes-1:0] res;
    logic [1:0]        num;
  } grp_t;

  // {valid, sextet} of a plain character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = {1'b1, 6'(c - ChUpA)};
    end else if (c >= ChLoA && c <= ChLoZ) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= ChDig0 && c <= ChDig8) begin
      r = {1'b1, 6'(c + 8'd4)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/b62d_apb.sv
// APB register file holding the output capacity.
module b62d_apb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [b62d_pkg::ApbAddrW-1:0]    paddr,
  input  logic [b62d_pkg::ApbDataW-1:0]    pwdata,
  output logic [b62d_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output logic [b62d_pkg::CapW-1:0]        cap_o
);

  logic [b62d_pkg::CapW-1:0] cap_q, cap_d;
  logic                      sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[2] == b62d_pkg::RegOutCapacity);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && sel_cap) begin
      cap_d = pwdata[b62d_pkg::CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= b62d_pkg::CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = sel_cap ? b62d_pkg::ApbDataW'(cap_q) : '0;
  assign cap_o  = cap_q;

endmodule

FILE: rtl/b62d_msg.sv
// Message state and single-pass decode of one character into a result group.
module b62d_msg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  b62d_pkg::in_t              in_i,
  input  logic [b62d_pkg::CapW-1:0]  cap_i,
  output b62d_pkg::grp_t             grp_o
);

  localparam int unsigned Cb = b62d_pkg::CountBits;
  localparam int unsigned Cw = b62d_pkg::CmpW;

  logic [2:0][5:0] store_q, store_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            esc_q, esc_d;
  logic [Cb-1:0]   bw_q, bw_d;
  logic            disc_q, disc_d;

  always_comb begin
    b62d_pkg::status_e err;
    logic              have;
    logic              finish;
    logic [5:0]        v;
    logic [6:0]        sx;
    logic [1:0]        n;
    logic [Cw-1:0]     cap_x;
    logic [7:0]        sym;
    logic [5:0]        s1;
    b62d_pkg::grp_t    g;

    sym    = in_i.symbol;
    finish = in_i.end_of_text;
    err    = b62d_pkg::StOk;
    have   = 1'b0;
    v      = '0;
    sx     = b62d_pkg::sextet_of(sym);
    n      = '0;
    cap_x  = Cw'(cap_i);
    s1     = '0;
    g      = '0;
    store_d = store_q;
    cnt_d   = cnt_q;
    esc_d   = esc_q;
    bw_d    = bw_q;
    disc_d  = disc_q;

    if (disc_q) begin
      if (in_i.end_of_text) begin
        disc_d = 1'b0;
        cnt_d  = '0;
        esc_d  = 1'b0;
        bw_d   = '0;
      end
    end else begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (sym >= b62d_pkg::ChUpA && sym <= b62d_pkg::ChUpC) begin
          v    = b62d_pkg::SxEscBase + 6'(sym - b62d_pkg::ChUpA);
          have = 1'b1;
        end else begin
          err = b62d_pkg::StBadEsc;
        end
      end else if (sym == b62d_pkg::ChNul) begin
        finish = 1'b1;
      end else if ((sym >= b62d_pkg::ChTab && sym <= b62d_pkg::ChCr) ||
                   sym == b62d_pkg::ChSpace) begin
        // whitespace
      end else if (sym == b62d_pkg::ChEscape) begin
        if (in_i.end_of_text) begin
          err = b62d_pkg::StEscEnd;
        end else begin
          esc_d = 1'b1;
        end
      end else if (sx[6]) begin
        v    = sx[5:0];
        have = 1'b1;
      end else begin
        err = b62d_pkg::StBadChar;
      end

      // full group
      if (err == b62d_pkg::StOk && have) begin
        if (cnt_q == 2'd3) begin
          if (Cw'(bw_q) + Cw'(2) >= cap_x) begin
            err = b62d_pkg::StOverflow;
          end else begin
            g.res[0] = '{data_byte: {store_q[0], store_q[1][5:4]}, byte_valid: 1'b1,
                         last: 1'b0, status: b62d_pkg::StOk};
            g.res[1] = '{data_byte: {store_q[1][3:0], store_q[2][5:2]}, byte_valid: 1'b1,
                         last: 1'b0, status: b62d_pkg::StOk};
            g.res[2] = '{data_byte: {store_q[2][1:0], v}, byte_valid: 1'b1,
                         last: 1'b0, status: b62d_pkg::StOk};
            n     = 2'd3;
            bw_d  = bw_q + Cb'(3);
            cnt_d = '0;
          end
        end else begin
          unique case (cnt_q)
            2'd0:    store_d[0] = v;
            2'd1:    store_d[1] = v;
            default: store_d[2] = v;
          endcase
          cnt_d = cnt_q + 2'd1;
        end
      end

      // remainder flush
      if (err == b62d_pkg::StOk && finish && cnt_d != 2'd0) begin
        s1 = (cnt_d >= 2'd2) ? store_d[1] : 6'd0;
        if (Cw'(bw_d) >= cap_x) begin
          err = b62d_pkg::StOverflow;
        end else if (cnt_d == 2'd1) begin
          g.res[n] = '{data_byte: {store_d[0], 2'b00}, byte_valid: 1'b1,
                       last: 1'b0, status: b62d_pkg::StOk};
          n    = n + 2'd1;
          bw_d = bw_d + Cb'(1);
        end else begin
          g.res[n] = '{data_byte: {store_d[0], s1[5:4]}, byte_valid: 1'b1,
                       last: 1'b0, status: b62d_pkg::StOk};
          n    = n + 2'd1;
          bw_d = bw_d + Cb'(1);
          if (cnt_d == 2'd3) begin
            if (Cw'(bw_d) >= cap_x) begin
              err = b62d_pkg::StOverflow;
            end else begin
              g.res[n] = '{data_byte: {s1[3:0], store_d[2][5:2]}, byte_valid: 1'b1,
                           last: 1'b0, status: b62d_pkg::StOk};
              n    = n + 2'd1;
              bw_d = bw_d + Cb'(1);
            end
          end
        end
      end

      if (err != b62d_pkg::StOk) begin
        g.res[n] = '{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1, status: err};
        n      = n + 2'd1;
        cnt_d  = '0;
        esc_d  = 1'b0;
        bw_d   = '0;
        disc_d = !in_i.end_of_text;
      end else if (finish) begin
        if (n == 2'd0) begin
          g.res[0] = '{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                       status: b62d_pkg::StOk};
          n = 2'd1;
        end else begin
          g.res[n - 2'd1].last = 1'b1;
        end
        cnt_d  = '0;
        esc_d  = 1'b0;
        bw_d   = '0;
        disc_d = !in_i.end_of_text;
      end
    end

    g.num = n;
    grp_o = g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      esc_q  <= 1'b0;
      bw_q   <= '0;
      disc_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      esc_q  <= esc_d;
      bw_q   <= bw_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

endmodule

FILE: rtl/b62d_outq.sv
// Result group register, handing out one word per cycle while out_ready_i is high.
module b62d_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  b62d_pkg::grp_t  grp_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b62d_pkg::out_t  out_data_o
);

  b62d_pkg::out_t [b62d_pkg::MaxRes-1:0] res_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;
  logic       pop_last;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = res_q[idx_q];
  assign pop         = out_valid_o && out_ready_i;
  assign pop_last    = pop && (idx_q + 2'd1 == cnt_q);
  assign can_load_o  = (cnt_q == 2'd0) || pop_last;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = grp_i.num;
      idx_d = '0;
    end else if (pop_last) begin
      cnt_d = '0;
      idx_d = '0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= grp_i.res;
    end
  end

endmodule

FILE: rtl/base62_sextet_decoder_core.sv
// Top level of the base62 sextet decoder: config port, decode and result register.
// The first result word of a character is valid in the cycle after it is accepted.
// One character per cycle is taken while the result register is empty; after one giving k
// words (k up to 3) the next, even one giving no word, waits until the last word is taken.
// Reset (async, active low) clears the message counters and flags, empties the result
// register without clearing its data, and sets the output capacity to 4096.
module base62_sextet_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  b62d_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output b62d_pkg::out_t                   out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [b62d_pkg::ApbAddrW-1:0]    paddr,
  input  logic [b62d_pkg::ApbDataW-1:0]    pwdata,
  output logic [b62d_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  logic                      cap_ok;
  logic [b62d_pkg::CapW-1:0] cap;
  logic                      accept;
  b62d_pkg::grp_t            grp;

  assign accept     = in_valid_i && cap_ok;
  assign in_ready_o = cap_ok;

  b62d_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  b62d_msg u_msg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .cap_i    (cap),
    .grp_o    (grp)
  );

  b62d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (grp.num != 2'd0)),
    .grp_i       (grp),
    .can_load_o  (cap_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
